>>> rtl/thrust_pid_with_filter_defines.svh
// assertion macros for the thrust pid controller
`ifndef THRUST_PID_WITH_FILTER_DEFINES_SVH
`define THRUST_PID_WITH_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TPF_ASSERT(lbl, prop, msg)
`define TPF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/tpf_pkg.sv
// types, constants and saturation helpers of the thrust pid controller
`timescale 1ns / 1ps
package tpf_pkg;

  localparam int MUL_AW = 48;
  localparam int MUL_BW = 24;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 24;
  localparam int GAIN_W = 24;
  localparam int ALPHA_W = 16;
  localparam int CFG_IW = 3;

  localparam logic REQ_ADC = 1'b0;
  localparam logic REQ_CAP = 1'b1;

  localparam logic [MUL_BW-1:0] THR_MUL = 24'd149445;
  localparam logic signed [MUL_PW-1:0] THR_OFS = 72'sd359565000;
  localparam logic [DIV_DW-1:0] THR_DIV = 24'd10500000;
  localparam logic [DIV_DW-1:0] CAP_DIV = 24'd5;
  localparam logic signed [16:0] CAP_OFS = 17'sd125;
  localparam logic [DIV_DW-1:0] DT_DIV = 24'd4000;
  localparam logic [MUL_BW-1:0] DER_MUL = 24'd4000;
  localparam logic [MUL_BW-1:0] PLS_MUL = 24'd125;
  localparam logic [7:0] PLS_BASE = 8'd125;
  localparam logic [DIV_DW-1:0] CMP_DIV = 24'd250;
  localparam logic [9:0] CMP_MAX = 10'd1023;

  localparam logic [ALPHA_W-1:0] RST_ALPHA = 16'd655;
  localparam logic [GAIN_W-1:0] RST_KFF = 24'd65536;
  localparam logic [GAIN_W-1:0] RST_KP = 24'd65536;
  localparam logic [GAIN_W-1:0] RST_KI = 24'd655360;
  localparam logic [GAIN_W-1:0] RST_KD = 24'd655;
  localparam logic [GAIN_W-1:0] RST_SCALE = 24'd2621;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ALPHA,
    CFG_KFF,
    CFG_KP,
    CFG_KI,
    CFG_KD,
    CFG_SCALE
  } tpf_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP,
    ST_ADC,
    ST_THR,
    ST_FLT,
    ST_ERR,
    ST_DER,
    ST_FF,
    ST_PRP,
    ST_DRV,
    ST_INT,
    ST_SCL,
    ST_PLS,
    ST_CMPM,
    ST_CMPD,
    ST_OUT
  } tpf_state_e;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic [MUL_BW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] n;
    logic [DIV_DW-1:0]        d;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIV_NW-1:0] q;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
    logic signed [31:0] r;
    if (x > 80'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -80'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [79:0] x);
    logic signed [47:0] r;
    if (x > 80'sh7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (x < -80'sh8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  // gain product in q8.16: floor by 2^16, then saturate
  function automatic logic signed [47:0] gmul_sat(input logic signed [MUL_PW-1:0] p);
    return sat48(80'(p >>> 16));
  endfunction

endpackage

>>> rtl/thrust_pid_with_filter.sv
// thrust pid controller top level: sequencer, state and registers
`timescale 1ns / 1ps
`include "thrust_pid_with_filter_defines.svh"
// request channel (in_valid_i / in_ready_o) carries either a pulse capture
// (req_type_i high) or a load cell converter sample (req_type_i low)
// a capture with nonzero period_count_i updates the thrust setpoint and
// gives no result; a capture with zero period is taken and dropped
// a converter sample runs mapping, filter and the pid step and gives one
// result on the result channel (out_valid_o / out_ready_i)
// all arithmetic goes through one bit-serial multiplier and one bit-serial
// divider; a sample takes ten products and three quotients, a capture
// takes one quotient
// one request is worked at a time; in_ready_o is high whenever the
// sequencer is idle, also while a result still waits in the output register
// if the receiver stalls, the next sample finishes its work and then holds
// until the output register is free
// config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once; indexes
// above the register list are ignored
// reset clears filter, integral, last error and setpoint and loads the
// default gains
module thrust_pid_with_filter #(
  parameter int FRAC_BITS  = 16,  // 8 .. 24
  parameter int PWM_PERIOD = 800  // 100 .. 65535
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [11:0]                adc_sample_i,
  input  logic [15:0]                period_count_i,
  input  logic [15:0]                width_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [9:0]                 compare_value_o,
  output logic [7:0]                 pulse_length_us_o,
  output logic                       clamped_high_o,
  output logic                       clamped_low_o,
  input  logic                       cfg_we_i,
  input  logic [tpf_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [tpf_pkg::GAIN_W-1:0] cfg_data_i
);
  import tpf_pkg::*;

  localparam logic signed [47:0] One = 48'sd1 <<< FRAC_BITS;

  // config registers
  logic [ALPHA_W-1:0] alpha_q;
  logic [GAIN_W-1:0]  kff_q, kp_q, ki_q, kd_q, scale_q;

  // controller state
  logic signed [31:0] filt_q, last_q, setp_q;
  logic signed [47:0] integ_q;

  // working registers of one request
  logic [11:0]        adc_q;
  logic [15:0]        width_q;
  logic signed [31:0] t0_q, e_q;
  logic signed [32:0] diff_q;
  logic signed [47:0] itent_q, der_q;
  logic signed [49:0] sum_q;
  logic [FRAC_BITS:0] cmd_q;
  logic [7:0]         pulse_q;
  logic [23:0]        cmpp_q;
  logic [9:0]         cmp_q;
  logic               chi_q, clo_q;

  logic               out_valid_q;
  logic [9:0]         out_cmp_q;
  logic [7:0]         out_pulse_q;
  logic               out_chi_q, out_clo_q;

  tpf_state_e state_q, state_d;
  logic       launched_q, op_done, out_load;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [31:0] e_calc;
  logic signed [16:0] cap_t;
  logic signed [47:0] gm;

  tpf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign e_calc   = sat32(80'(setp_q) - 80'(filt_q));
  assign cap_t    = $signed({2'b00, width_q[15:1]}) - CAP_OFS;
  assign gm       = gmul_sat(mul_rsp.p);
  assign op_done  = launched_q && (mul_rsp.done || div_rsp.done);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and operand launch; each step launches once, then waits
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_CAP) begin
            state_d = (period_count_i != '0) ? ST_CAP : ST_IDLE;
          end else begin
            state_d = ST_ADC;
          end
        end
      end
      ST_CAP: begin
        div_req.start = !launched_q;
        div_req.n     = DIV_NW'(cap_t) <<< FRAC_BITS;
        div_req.d     = CAP_DIV;
        if (op_done) state_d = ST_IDLE;
      end
      ST_ADC: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'({1'b0, adc_q});
        mul_req.b     = THR_MUL;
        if (op_done) state_d = ST_THR;
      end
      ST_THR: begin
        div_req.start = !launched_q;
        div_req.n     = DIV_NW'(t0_q) <<< FRAC_BITS;
        div_req.d     = THR_DIV;
        if (op_done) state_d = ST_FLT;
      end
      ST_FLT: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(diff_q);
        mul_req.b     = MUL_BW'(alpha_q);
        if (op_done) state_d = ST_ERR;
      end
      ST_ERR: begin
        div_req.start = !launched_q;
        div_req.n     = DIV_NW'(e_calc);
        div_req.d     = DT_DIV;
        if (op_done) state_d = ST_DER;
      end
      ST_DER: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(33'(e_q) - 33'(last_q));
        mul_req.b     = DER_MUL;
        if (op_done) state_d = ST_FF;
      end
      ST_FF: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(setp_q);
        mul_req.b     = kff_q;
        if (op_done) state_d = ST_PRP;
      end
      ST_PRP: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(e_q);
        mul_req.b     = kp_q;
        if (op_done) state_d = ST_DRV;
      end
      ST_DRV: begin
        mul_req.start = !launched_q;
        mul_req.a     = der_q;
        mul_req.b     = kd_q;
        if (op_done) state_d = ST_INT;
      end
      ST_INT: begin
        mul_req.start = !launched_q;
        mul_req.a     = itent_q;
        mul_req.b     = ki_q;
        if (op_done) state_d = ST_SCL;
      end
      ST_SCL: begin
        mul_req.start = !launched_q;
        mul_req.a     = sat48(80'(sum_q));
        mul_req.b     = scale_q;
        if (op_done) state_d = ST_PLS;
      end
      ST_PLS: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(cmd_q);
        mul_req.b     = PLS_MUL;
        if (op_done) state_d = ST_CMPM;
      end
      ST_CMPM: begin
        mul_req.start = !launched_q;
        mul_req.a     = MUL_AW'(pulse_q);
        mul_req.b     = MUL_BW'(PWM_PERIOD);
        if (op_done) state_d = ST_CMPD;
      end
      ST_CMPD: begin
        div_req.start = !launched_q;
        div_req.n     = DIV_NW'(cmpp_q);
        div_req.d     = CMP_DIV;
        if (op_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
    endcase
  end

  // control flags, config and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      alpha_q     <= RST_ALPHA;
      kff_q       <= RST_KFF;
      kp_q        <= RST_KP;
      ki_q        <= RST_KI;
      kd_q        <= RST_KD;
      scale_q     <= RST_SCALE;
      filt_q      <= '0;
      integ_q     <= '0;
      last_q      <= '0;
      setp_q      <= '0;
    end else begin
      if (mul_req.start || div_req.start) begin
        launched_q <= 1'b1;
      end else if (op_done) begin
        launched_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
          CFG_KFF:   kff_q   <= cfg_data_i;
          CFG_KP:    kp_q    <= cfg_data_i;
          CFG_KI:    ki_q    <= cfg_data_i;
          CFG_KD:    kd_q    <= cfg_data_i;
          CFG_SCALE: scale_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (op_done) begin
        unique case (state_q)
          ST_CAP: setp_q <= sat32(80'(div_rsp.q));
          ST_FLT: filt_q <= sat32(80'(filt_q) + 80'(mul_rsp.p >>> 16));
          ST_SCL: begin
            // clamp holds the integral, so this step's increment is dropped
            if (!(gm > One) && !(gm < 48'sd0)) begin
              integ_q <= itent_q;
            end
            last_q <= e_q;
          end
          default: ;
        endcase
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      adc_q   <= adc_sample_i;
      width_q <= width_count_i;
    end
    if (state_q == ST_ERR && div_req.start) begin
      e_q <= e_calc;
    end
    if (op_done) begin
      unique case (state_q)
        ST_ADC:  t0_q   <= 32'(mul_rsp.p - THR_OFS);
        ST_THR:  diff_q <= 33'(sat32(80'(div_rsp.q))) - 33'(filt_q);
        ST_ERR:  itent_q <= sat48(80'(integ_q) + 80'(div_rsp.q));
        ST_DER:  der_q  <= sat48(80'(mul_rsp.p));
        ST_FF:   sum_q  <= 50'(gm);
        ST_PRP,
        ST_DRV,
        ST_INT:  sum_q  <= sum_q + 50'(gm);
        ST_SCL: begin
          if (gm > One) begin
            cmd_q <= (FRAC_BITS + 1)'(One);
            chi_q <= 1'b1;
            clo_q <= 1'b0;
          end else if (gm < 48'sd0) begin
            cmd_q <= '0;
            chi_q <= 1'b0;
            clo_q <= 1'b1;
          end else begin
            cmd_q <= gm[FRAC_BITS:0];
            chi_q <= 1'b0;
            clo_q <= 1'b0;
          end
        end
        ST_PLS:  pulse_q <= PLS_BASE + 8'(mul_rsp.p >>> FRAC_BITS);
        ST_CMPM: cmpp_q <= mul_rsp.p[23:0];
        ST_CMPD: cmp_q  <= (div_rsp.q > 56'sd1023) ? CMP_MAX : div_rsp.q[9:0];
        default: ;
      endcase
    end
    if (out_load) begin
      out_cmp_q   <= cmp_q;
      out_pulse_q <= pulse_q;
      out_chi_q   <= chi_q;
      out_clo_q   <= clo_q;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign compare_value_o   = out_cmp_q;
  assign pulse_length_us_o = out_pulse_q;
  assign clamped_high_o    = out_chi_q;
  assign clamped_low_o     = out_clo_q;

  `TPF_ASSERT(a_one_unit, !(mul_rsp.busy && div_rsp.busy), "multiplier and divider both busy")
  `TPF_ASSERT(a_clamp_excl, out_valid_o |-> !(clamped_high_o && clamped_low_o), "both clamp flags set")
  `TPF_ASSERT(a_pulse_range, out_valid_o |-> (pulse_length_us_o >= 8'd125 && pulse_length_us_o <= 8'd250), "pulse out of range")

endmodule

>>> rtl/tpf_mul.sv
// bit-serial shift-add multiplier, signed by unsigned
`timescale 1ns / 1ps
`include "thrust_pid_with_filter_defines.svh"
module tpf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpf_pkg::mul_req_t req_i,
  output tpf_pkg::mul_rsp_t rsp_o
);
  import tpf_pkg::*;

  localparam int CntW = $clog2(MUL_BW);

  logic signed [MUL_PW-1:0] mcand_q, acc_q;
  logic [MUL_BW-1:0]        mplier_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle, lsb first
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q  <= MUL_PW'(req_i.a);
      mplier_q <= req_i.b;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

  `TPF_ASSERT(a_mul_no_restart, req_i.start |-> !busy_q, "multiplier restarted while busy")
  `TPF_ASSERT(a_mul_done_idle, done_q |-> !busy_q, "multiplier done while busy")

endmodule

>>> rtl/tpf_div.sv
// bit-serial restoring divider with floor rounding for negative numerators
`timescale 1ns / 1ps
`include "thrust_pid_with_filter_defines.svh"
module tpf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpf_pkg::div_req_t req_i,
  output tpf_pkg::div_rsp_t rsp_o
);
  import tpf_pkg::*;

  localparam int CntW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num_q, quo_q;
  logic [DIV_DW-1:0] rem_q, d_q;
  logic [DIV_DW:0]   trial;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q, busy_q, done_q, fit;
  logic signed [DIV_NW-1:0] quo_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign trial = {rem_q, num_q[DIV_NW-1]};
  assign fit   = (trial >= {1'b0, d_q});

  // one quotient bit per cycle on the magnitude
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.n[DIV_NW-1];
      num_q <= req_i.n[DIV_NW-1] ? DIV_NW'(-req_i.n) : DIV_NW'(req_i.n);
      d_q   <= req_i.d;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? DIV_DW'(trial - {1'b0, d_q}) : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fit};
      num_q <= num_q << 1;
    end
  end

  // floor for negative numerators: -(q+1) when inexact
  always_comb begin
    if (!neg_q) begin
      quo_out = quo_q;
    end else if (rem_q != '0) begin
      quo_out = ~quo_q;
    end else begin
      quo_out = -quo_q;
    end
  end

  assign rsp_o.q    = quo_out;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

  `TPF_ASSERT(a_div_no_restart, req_i.start |-> !busy_q, "divider restarted while busy")
  `TPF_ASSERT(a_div_nonzero, req_i.start |-> (req_i.d != '0), "divider started with zero divisor")

endmodule
